### hw/rtl/tlg_pkg.sv
// Shared widths, reset values, register indexes, layout codes and stage payload types.
package tlg_pkg;

	// Field widths
	localparam int DimW   = 14;
	localparam int GapW   = 10;
	localparam int CountW = 8;
	localparam int IndexW = 3;
	localparam int CoordW = 16;
	localparam int RegIdxW = 2;

	// Register reset values
	localparam logic [DimW-1:0] SCREEN_W_RST = 14'd1920;
	localparam logic [DimW-1:0] SCREEN_H_RST = 14'd1080;
	localparam logic [GapW-1:0] SPACING_RST  = 10'd0;

	// Register indexes
	localparam logic [RegIdxW-1:0] REG_SCREEN_W = 2'd0;
	localparam logic [RegIdxW-1:0] REG_SCREEN_H = 2'd1;
	localparam logic [RegIdxW-1:0] REG_SPACING  = 2'd2;

	// Layouts selected by the tile count
	localparam logic [CountW-1:0] LAYOUT_FULL       = 8'd1;
	localparam logic [CountW-1:0] LAYOUT_COLS2      = 8'd2;
	localparam logic [CountW-1:0] LAYOUT_MAIN_STACK = 8'd3;
	localparam logic [CountW-1:0] LAYOUT_GRID2X2    = 8'd4;
	localparam logic [CountW-1:0] LAYOUT_ROWS23     = 8'd5;
	localparam logic [CountW-1:0] LAYOUT_GRID3X2    = 8'd6;
	localparam logic [CountW-1:0] LAYOUT_ROWS34     = 8'd7;
	localparam logic [CountW-1:0] LAYOUT_GRID4X2    = 8'd8;

	// Reciprocal of three, exact for 14-bit magnitudes with a 17-bit shift
	localparam logic [15:0] RECIP3       = 16'd43691;
	localparam int          RECIP3_SHIFT = 17;

	// Decoded request with numerators, after stage 1
	typedef struct packed {
		logic [2:0]               ncols;
		logic [IndexW-1:0]        col;
		logic [IndexW-1:0]        row;
		logic                     full_h;
		logic                     zero;
		logic signed [CoordW-1:0] num_w;
		logic signed [CoordW-1:0] num_h;
		logic signed [CoordW-1:0] full_hgt;
	} s1_t;

	// Column width and row height, after stage 2
	typedef struct packed {
		logic [IndexW-1:0]        col;
		logic [IndexW-1:0]        row;
		logic                     full_h;
		logic                     zero;
		logic signed [CoordW-1:0] col_w;
		logic signed [CoordW-1:0] row_h;
		logic signed [CoordW-1:0] full_hgt;
	} s2_t;

	// Final rectangle, after stage 3
	typedef struct packed {
		logic signed [CoordW-1:0] left_x;
		logic signed [CoordW-1:0] top_y;
		logic signed [CoordW-1:0] tile_width;
		logic signed [CoordW-1:0] tile_height;
	} s3_t;

endpackage

### hw/rtl/tlg_query_if.sv
// Request channel: tile count and tile index with valid/ready.
interface tlg_query_if;
	import tlg_pkg::*;

	logic              valid;
	logic              ready;
	logic [CountW-1:0] tile_count;
	logic [IndexW-1:0] tile_index;

	modport source (output valid, output tile_count, output tile_index, input ready);
	modport sink   (input valid, input tile_count, input tile_index, output ready);
endinterface

### hw/rtl/tlg_result_if.sv
// Result channel: tile rectangle with valid/ready.
interface tlg_result_if;
	import tlg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] left_x;
	logic signed [CoordW-1:0] top_y;
	logic signed [CoordW-1:0] tile_width;
	logic signed [CoordW-1:0] tile_height;

	modport source (output valid, output left_x, output top_y, output tile_width,
		output tile_height, input ready);
	modport sink   (input valid, input left_x, input top_y, input tile_width,
		input tile_height, output ready);
endinterface

### hw/rtl/tlg_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
interface tlg_cfg_if;
	import tlg_pkg::*;

	logic               valid;
	logic               ready;
	logic [RegIdxW-1:0] index;
	logic [DimW-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/tlg_decode.sv
// Stage 1: decode layout, column and row of the tile, and form the numerators.
module tlg_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        prev_valid,
	output logic                        prev_ready,
	input  logic [tlg_pkg::CountW-1:0]  tile_count,
	input  logic [tlg_pkg::IndexW-1:0]  tile_index,
	input  logic [tlg_pkg::DimW-1:0]    screen_w,
	input  logic [tlg_pkg::DimW-1:0]    screen_h,
	input  logic [tlg_pkg::GapW-1:0]    spacing,
	output logic                        next_valid,
	input  logic                        next_ready,
	output tlg_pkg::s1_t                next_data
);
	import tlg_pkg::*;

	logic              valid_s1;
	s1_t               data_s1;
	s1_t               dec;
	s1_t               req;
	logic [12:0]       gap2;
	logic [12:0]       gap3;
	logic [12:0]       gap_k;

	// Gap multiples
	assign gap2 = {2'b0, spacing, 1'b0};
	assign gap3 = {3'b0, spacing} + {2'b0, spacing, 1'b0};

	// Pick the column count, column and row of this tile
	always_comb begin
		dec.ncols    = 3'd2;
		dec.col      = '0;
		dec.row      = '0;
		dec.full_h   = 1'b0;
		dec.zero     = 1'b0;
		dec.num_w    = '0;
		dec.num_h    = '0;
		dec.full_hgt = '0;
		case (tile_count)
			LAYOUT_FULL: begin
				dec.ncols  = 3'd1;
				dec.full_h = 1'b1;
			end
			LAYOUT_COLS2: begin
				dec.col    = tile_index;
				dec.full_h = 1'b1;
			end
			LAYOUT_MAIN_STACK: begin
				if (tile_index == 3'd0) begin
					dec.full_h = 1'b1;
				end else begin
					dec.col = 3'd1;
					dec.row = tile_index - 3'd1;
				end
			end
			LAYOUT_GRID2X2: begin
				dec.row = {1'b0, tile_index[2:1]};
				dec.col = {2'b0, tile_index[0]};
			end
			LAYOUT_GRID3X2: begin
				dec.ncols = 3'd3;
				if (tile_index >= 3'd6) begin
					dec.row = 3'd2;
					dec.col = tile_index - 3'd6;
				end else if (tile_index >= 3'd3) begin
					dec.row = 3'd1;
					dec.col = tile_index - 3'd3;
				end else begin
					dec.col = tile_index;
				end
			end
			LAYOUT_GRID4X2: begin
				dec.ncols = 3'd4;
				dec.row   = {2'b0, tile_index[2]};
				dec.col   = {1'b0, tile_index[1:0]};
			end
			LAYOUT_ROWS23: begin
				if (tile_index < 3'd2) begin
					dec.col = tile_index;
				end else begin
					dec.ncols = 3'd3;
					dec.col   = tile_index - 3'd2;
					dec.row   = 3'd1;
				end
			end
			LAYOUT_ROWS34: begin
				if (tile_index < 3'd3) begin
					dec.ncols = 3'd3;
					dec.col   = tile_index;
				end else begin
					dec.ncols = 3'd4;
					dec.col   = tile_index - 3'd3;
					dec.row   = 3'd1;
				end
			end
			default: begin
				dec.zero = 1'b1;
			end
		endcase
	end

	// Gap total across a row of n columns: (n + 1) * gap
	always_comb begin
		case (dec.ncols)
			3'd1:    gap_k = gap2;
			3'd2:    gap_k = gap3;
			3'd3:    gap_k = {1'b0, spacing, 2'b0};
			3'd4:    gap_k = {1'b0, spacing, 2'b0} + {3'b0, spacing};
			default: gap_k = gap2;
		endcase
	end

	// Attach the width and height numerators
	always_comb begin
		req          = dec;
		req.num_w    = $signed({2'b0, screen_w}) - $signed({3'b0, gap_k});
		req.num_h    = $signed({2'b0, screen_h}) - $signed({3'b0, gap3});
		req.full_hgt = $signed({2'b0, screen_h}) - $signed({3'b0, gap2});
	end

	assign prev_ready = !valid_s1 || next_ready;

	// Advance stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (prev_ready) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready && prev_valid) begin
			data_s1 <= req;
		end
	end

	assign next_valid = valid_s1;
	assign next_data  = data_s1;
endmodule

### hw/rtl/tlg_divide.sv
// Stage 2: truncating divide of the width by the column count and of the height by two.
module tlg_divide (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         prev_valid,
	output logic         prev_ready,
	input  tlg_pkg::s1_t prev_data,
	output logic         next_valid,
	input  logic         next_ready,
	output tlg_pkg::s2_t next_data
);
	import tlg_pkg::*;

	logic                     valid_s2;
	s2_t                      data_s2;
	logic                     neg_w;
	logic [CoordW-1:0]        neg_num;
	logic [DimW-1:0]          mag;
	logic [DimW+15:0]         prod3;
	logic [DimW-1:0]          quot;
	logic signed [CoordW-1:0] col_w;
	logic signed [CoordW-1:0] half_adj;
	logic signed [CoordW-1:0] row_h;

	// Split width numerator into sign and magnitude
	assign neg_w   = prev_data.num_w[CoordW-1];
	assign neg_num = -prev_data.num_w;
	assign mag     = neg_w ? neg_num[DimW-1:0] : prev_data.num_w[DimW-1:0];
	assign prod3   = mag * RECIP3;

	// Divide magnitude by the column count
	always_comb begin
		case (prev_data.ncols)
			3'd2:    quot = {1'b0, mag[DimW-1:1]};
			3'd3:    quot = {1'b0, prod3[DimW+15:RECIP3_SHIFT]};
			3'd4:    quot = {2'b0, mag[DimW-1:2]};
			default: quot = mag;
		endcase
	end

	assign col_w = neg_w ? -$signed({2'b0, quot}) : $signed({2'b0, quot});

	// Halve height toward zero: bias negatives by one before the shift
	assign half_adj = prev_data.num_h + $signed({15'b0, prev_data.num_h[CoordW-1]});
	assign row_h    = half_adj >>> 1;

	assign prev_ready = !valid_s2 || next_ready;

	// Advance stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (prev_ready) begin
			valid_s2 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready && prev_valid) begin
			data_s2.col      <= prev_data.col;
			data_s2.row      <= prev_data.row;
			data_s2.full_h   <= prev_data.full_h;
			data_s2.zero     <= prev_data.zero;
			data_s2.col_w    <= col_w;
			data_s2.row_h    <= row_h;
			data_s2.full_hgt <= prev_data.full_hgt;
		end
	end

	assign next_valid = valid_s2;
	assign next_data  = data_s2;
endmodule

### hw/rtl/tlg_place.sv
// Stage 3: place the tile from column, row and pitch; this is the result register.
module tlg_place (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     prev_valid,
	output logic                     prev_ready,
	input  tlg_pkg::s2_t             prev_data,
	input  logic [tlg_pkg::GapW-1:0] spacing,
	output logic                     next_valid,
	input  logic                     next_ready,
	output tlg_pkg::s3_t             next_data
);
	import tlg_pkg::*;

	logic              valid_s3;
	s3_t               data_s3;
	s3_t               rect;
	logic [CoordW-1:0] gap16;
	logic [CoordW-1:0] pitch_x;
	logic [CoordW-1:0] pitch_y;
	logic [CoordW-1:0] off_x;
	logic [CoordW-1:0] off_y;

	// Offsets wrap at 16 bits, as the outputs do
	assign gap16   = {6'b0, spacing};
	assign pitch_x = prev_data.col_w + gap16;
	assign pitch_y = prev_data.row_h + gap16;
	assign off_x   = pitch_x * {13'b0, prev_data.col};
	assign off_y   = pitch_y * {13'b0, prev_data.row};

	// Build rectangle, zero for counts without a layout
	always_comb begin
		if (prev_data.zero) begin
			rect = '0;
		end else begin
			rect.left_x      = off_x + gap16;
			rect.top_y       = off_y + gap16;
			rect.tile_width  = prev_data.col_w;
			rect.tile_height = prev_data.full_h ? prev_data.full_hgt : prev_data.row_h;
		end
	end

	assign prev_ready = !valid_s3 || next_ready;

	// Advance stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (prev_ready) begin
			valid_s3 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready && prev_valid) begin
			data_s3 <= rect;
		end
	end

	assign next_valid = valid_s3;
	assign next_data  = data_s3;
endmodule

### hw/rtl/tile_layout_geometry_top.sv
// Top level of the tile layout geometry block: config registers and three-stage pipeline.
//
// Usage:
//   query  - request channel carrying tile_count and tile_index.
//   result - rectangle of that tile: left_x, top_y, tile_width, tile_height,
//            16-bit two's complement; counts outside one to eight give zeros.
//   cfg    - register writes: index 0 viewport width, 1 viewport height,
//            2 tile gap; other indexes are dropped. Always ready.
//            Write only while no request is in flight.
// Flow: a request accepted on query is registered by the decode, divide and
//   place stages in turn, then shows on result.
// Throughput: one request per cycle while result.ready is high, set by the
//   three-stage pipeline with a single reciprocal multiplier in the divide stage.
// Reset: arst_n clears all stage valid bits and loads viewport 1920 x 1080
//   with a zero gap.
// Stall: when result.ready is low the result register holds its request and
//   the stages behind it fill up, then query.ready drops; nothing is lost.
module tile_layout_geometry_top (
	input  logic         clk,
	input  logic         arst_n,
	tlg_query_if.sink    query,
	tlg_result_if.source result,
	tlg_cfg_if.sink      cfg
);
	import tlg_pkg::*;

	logic [DimW-1:0] screen_w_q;
	logic [DimW-1:0] screen_h_q;
	logic [GapW-1:0] spacing_q;

	logic s1_valid;
	logic s1_ready;
	s1_t  s1_data;
	logic s2_valid;
	logic s2_ready;
	s2_t  s2_data;
	s3_t  s3_data;

	assign cfg.ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= SCREEN_W_RST;
			screen_h_q <= SCREEN_H_RST;
			spacing_q  <= SPACING_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SCREEN_W: screen_w_q <= cfg.data;
				REG_SCREEN_H: screen_h_q <= cfg.data;
				REG_SPACING:  spacing_q  <= cfg.data[GapW-1:0];
				default: ;
			endcase
		end
	end

	tlg_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (query.valid),
		.prev_ready (query.ready),
		.tile_count (query.tile_count),
		.tile_index (query.tile_index),
		.screen_w   (screen_w_q),
		.screen_h   (screen_h_q),
		.spacing    (spacing_q),
		.next_valid (s1_valid),
		.next_ready (s1_ready),
		.next_data  (s1_data)
	);

	tlg_divide u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (s1_valid),
		.prev_ready (s1_ready),
		.prev_data  (s1_data),
		.next_valid (s2_valid),
		.next_ready (s2_ready),
		.next_data  (s2_data)
	);

	tlg_place u_place (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (s2_valid),
		.prev_ready (s2_ready),
		.prev_data  (s2_data),
		.spacing    (spacing_q),
		.next_valid (result.valid),
		.next_ready (result.ready),
		.next_data  (s3_data)
	);

	assign result.left_x      = s3_data.left_x;
	assign result.top_y       = s3_data.top_y;
	assign result.tile_width  = s3_data.tile_width;
	assign result.tile_height = s3_data.tile_height;
endmodule

### bench/tile_layout_geometry_top_tb.sv
// Self-checking testbench for the tile layout geometry block: directed table, then random phases.
`timescale 1ns / 1ps

module tile_layout_geometry_top_tb;
	import tlg_pkg::*;

	// Register index that maps to no register
	localparam logic [RegIdxW-1:0] REG_UNMAPPED = 2'd3;
	localparam int NUM_PHASES      = 8;
	localparam int REQS_PER_PHASE  = 62;
	localparam int TAIL_CYCLES     = 8;

	typedef struct {
		logic               is_write;
		logic [RegIdxW-1:0] reg_index;
		logic [DimW-1:0]    reg_data;
		logic [CountW-1:0]  tile_count;
		logic [IndexW-1:0]  tile_index;
		logic               typed;
		s3_t                rect;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tlg_query_if  query_ch();
	tlg_result_if result_ch();
	tlg_cfg_if    cfg_ch();

	tile_layout_geometry_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the viewport registers
	logic [DimW-1:0] vp_width;
	logic [DimW-1:0] vp_height;
	logic [GapW-1:0] gap_px;

	s3_t       pending_rects[$];
	stim_row_t stim_table[$];
	int        src_idle_pct;
	int        sink_stall_pct;
	int        mismatch_count;
	int        sent_queries;
	int        checked_rects;
	int        reg_writes;

	// Column width for a row of ncols tiles, truncating toward zero
	function automatic longint col_span(input longint ncols);
		return (longint'(vp_width) - (ncols + 1) * longint'(gap_px)) / ncols;
	endfunction

	// Row height of the two-row layouts
	function automatic longint row_span();
		return (longint'(vp_height) - 3 * longint'(gap_px)) / 2;
	endfunction

	// Rectangle of one tile under the current viewport settings
	function automatic s3_t tile_rect(input logic [CountW-1:0] count,
		input logic [IndexW-1:0] idx);
		longint g;
		longint pos;
		longint ncols;
		longint x;
		longint y;
		longint w;
		longint h;
		s3_t    rect;
		g = longint'(gap_px);
		pos = longint'(idx);
		x = 0;
		y = 0;
		w = 0;
		h = 0;
		case (count)
		LAYOUT_FULL: begin
			x = g;
			y = g;
			w = longint'(vp_width) - 2 * g;
			h = longint'(vp_height) - 2 * g;
		end
		LAYOUT_COLS2: begin
			w = col_span(2);
			x = g + pos * (w + g);
			y = g;
			h = longint'(vp_height) - 2 * g;
		end
		LAYOUT_MAIN_STACK: begin
			w = col_span(2);
			if (pos == 0) begin
				x = g;
				y = g;
				h = longint'(vp_height) - 2 * g;
			end else begin
				h = row_span();
				x = g + w + g;
				y = g + (pos - 1) * (h + g);
			end
		end
		LAYOUT_GRID2X2, LAYOUT_GRID3X2, LAYOUT_GRID4X2: begin
			ncols = longint'(count) / 2;
			w = col_span(ncols);
			h = row_span();
			x = g + (pos % ncols) * (w + g);
			y = g + (pos / ncols) * (h + g);
		end
		LAYOUT_ROWS23, LAYOUT_ROWS34: begin
			ncols = longint'(count) / 2;
			h = row_span();
			if (pos < ncols) begin
				w = col_span(ncols);
				x = g + pos * (w + g);
				y = g;
			end else begin
				w = col_span(ncols + 1);
				x = g + (pos - ncols) * (w + g);
				y = g + h + g;
			end
		end
		default: begin
		end
		endcase
		rect.left_x      = x[CoordW-1:0];
		rect.top_y       = y[CoordW-1:0];
		rect.tile_width  = w[CoordW-1:0];
		rect.tile_height = h[CoordW-1:0];
		return rect;
	endfunction

	function automatic stim_row_t query_row(input int count, input int idx);
		stim_row_t row;
		row = '{default: '0};
		row.tile_count = CountW'(count);
		row.tile_index = IndexW'(idx);
		return row;
	endfunction

	function automatic stim_row_t typed_row(input int count, input int idx,
		input int x, input int y, input int w, input int h);
		stim_row_t row;
		row = query_row(count, idx);
		row.typed = 1'b1;
		row.rect.left_x      = CoordW'(x);
		row.rect.top_y       = CoordW'(y);
		row.rect.tile_width  = CoordW'(w);
		row.rect.tile_height = CoordW'(h);
		return row;
	endfunction

	function automatic stim_row_t write_row(input logic [RegIdxW-1:0] idx, input int data);
		stim_row_t row;
		row = '{default: '0};
		row.is_write  = 1'b1;
		row.reg_index = idx;
		row.reg_data  = DimW'(data);
		return row;
	endfunction

	function automatic void check_field(input string name, input logic signed [CoordW-1:0] want,
		input logic signed [CoordW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Issue one request, waiting out random idle cycles first
	task automatic send_query(input logic [CountW-1:0] count, input logic [IndexW-1:0] idx,
		input logic use_typed, input s3_t typed_rect);
		while ($urandom_range(99) < src_idle_pct) begin
			query_ch.valid <= 1'b0;
			@(posedge clk);
		end
		query_ch.valid      <= 1'b1;
		query_ch.tile_count <= count;
		query_ch.tile_index <= idx;
		@(posedge clk);
		while (!query_ch.ready) @(posedge clk);
		pending_rects.push_back(use_typed ? typed_rect : tile_rect(count, idx));
		sent_queries++;
	endtask

	// Drain the pipeline, then write one register and track it
	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DimW-1:0] data);
		query_ch.valid <= 1'b0;
		while (pending_rects.size() != 0) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
		REG_SCREEN_W: vp_width = data;
		REG_SCREEN_H: vp_height = data;
		REG_SPACING:  gap_px = data[GapW-1:0];
		default: begin
		end
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on run time
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Receiver backpressure
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each returned rectangle with the oldest expected one
	always @(posedge clk) begin
		s3_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_rects.size() == 0) begin
				$error("result: unexpected rectangle %0d,%0d %0dx%0d", result_ch.left_x,
					result_ch.top_y, result_ch.tile_width, result_ch.tile_height);
				mismatch_count++;
			end else begin
				want = pending_rects.pop_front();
				check_field("left_x", want.left_x, result_ch.left_x);
				check_field("top_y", want.top_y, result_ch.top_y);
				check_field("tile_width", want.tile_width, result_ch.tile_width);
				check_field("tile_height", want.tile_height, result_ch.tile_height);
				checked_rects++;
			end
		end
	end

	// Stimulus
	initial begin
		logic [CountW-1:0] cnt;
		logic [IndexW-1:0] idx;
		logic [DimW-1:0]   w_cfg;
		logic [DimW-1:0]   h_cfg;
		logic [GapW-1:0]   g_cfg;
		logic [3:0]        gap_junk;
		int                roll;

		arst_n              <= 1'b0;
		query_ch.valid      <= 1'b0;
		query_ch.tile_count <= '0;
		query_ch.tile_index <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= '0;
		cfg_ch.data         <= '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		mismatch_count = 0;
		sent_queries   = 0;
		checked_rects  = 0;
		reg_writes     = 0;
		vp_width  = SCREEN_W_RST;
		vp_height = SCREEN_H_RST;
		gap_px    = SPACING_RST;

		// Directed rows: reset viewport, then the extreme settings
		stim_table.push_back(typed_row(1, 0, 0, 0, 1920, 1080));
		stim_table.push_back(typed_row(1, 5, 0, 0, 1920, 1080));
		stim_table.push_back(typed_row(0, 0, 0, 0, 0, 0));
		stim_table.push_back(typed_row(255, 7, 0, 0, 0, 0));
		stim_table.push_back(typed_row(9, 3, 0, 0, 0, 0));
		stim_table.push_back(typed_row(2, 1, 960, 0, 960, 1080));
		stim_table.push_back(query_row(3, 0));
		stim_table.push_back(query_row(3, 2));
		stim_table.push_back(typed_row(4, 3, 960, 540, 960, 540));
		stim_table.push_back(query_row(5, 4));
		stim_table.push_back(query_row(6, 5));
		stim_table.push_back(query_row(7, 6));
		stim_table.push_back(typed_row(8, 7, 1440, 540, 480, 540));
		// Zero viewport with the widest gap: negative sizes
		stim_table.push_back(write_row(REG_SCREEN_W, 0));
		stim_table.push_back(write_row(REG_SCREEN_H, 0));
		stim_table.push_back(write_row(REG_SPACING, 1023));
		stim_table.push_back(typed_row(1, 0, 1023, 1023, -2046, -2046));
		stim_table.push_back(query_row(3, 1));
		stim_table.push_back(query_row(7, 3));
		stim_table.push_back(query_row(5, 2));
		// Largest viewport, gap write with upper data bits set: index past count wraps
		stim_table.push_back(write_row(REG_SCREEN_W, 16383));
		stim_table.push_back(write_row(REG_SCREEN_H, 16383));
		stim_table.push_back(write_row(REG_SPACING, 'h3C00));
		stim_table.push_back(query_row(2, 7));
		stim_table.push_back(query_row(8, 7));
		stim_table.push_back(query_row(3, 7));
		stim_table.push_back(query_row(6, 7));
		// Unmapped register index must leave the viewport alone
		stim_table.push_back(write_row(REG_UNMAPPED, 'h1234));
		stim_table.push_back(typed_row(1, 0, 0, 0, 16383, 16383));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].is_write) begin
				write_reg(stim_table[i].reg_index, stim_table[i].reg_data);
			end else begin
				send_query(stim_table[i].tile_count, stim_table[i].tile_index,
					stim_table[i].typed, stim_table[i].rect);
			end
		end

		// Random phases, each with its own viewport, rotating through four idle and stall patterns
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			w_cfg = DimW'($urandom_range(16383));
			h_cfg = DimW'($urandom_range(16383));
			g_cfg = GapW'($urandom_range(1023));
			case (ph)
			0: begin
				w_cfg = 14'd1920;
				h_cfg = 14'd1080;
				g_cfg = 10'd8;
			end
			1: begin
				w_cfg = '0;
				h_cfg = '0;
				g_cfg = '1;
			end
			2: begin
				w_cfg = '1;
				h_cfg = '1;
				g_cfg = '0;
			end
			4: begin
				w_cfg = '1;
				h_cfg = '0;
				g_cfg = '1;
			end
			5: g_cfg = GapW'($urandom_range(40));
			7: g_cfg = '1;
			default: begin
			end
			endcase
			gap_junk = 4'($urandom_range(15));
			write_reg(REG_SCREEN_W, w_cfg);
			write_reg(REG_SCREEN_H, h_cfg);
			write_reg(REG_SPACING, {gap_junk, g_cfg});

			case (ph % 4)
			0: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct   = 81;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct   = 0;
				sink_stall_pct = 81;
			end
			default: begin
				src_idle_pct   = 35;
				sink_stall_pct = 35;
			end
			endcase

			// Mostly in-range tiles, some past the count, some invalid counts
			for (int n = 0; n < REQS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < 80) begin
					cnt = CountW'($urandom_range(8, 1));
					idx = IndexW'($urandom_range(int'(cnt) - 1));
				end else if (roll < 90) begin
					cnt = CountW'($urandom_range(8, 1));
					idx = IndexW'($urandom_range(7));
				end else begin
					cnt = CountW'($urandom_range(255));
					idx = IndexW'($urandom_range(7));
				end
				send_query(cnt, idx, 1'b0, '0);
			end
		end

		// Drain and let any stray result show up
		query_ch.valid <= 1'b0;
		while (pending_rects.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d tile requests (all eight layouts and invalid counts), %0d checked,",
			sent_queries, checked_rects);
		$display("across %0d register writes including zero and full-scale viewports.",
			reg_writes);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/tlg_pkg.sv
hw/rtl/tlg_query_if.sv
hw/rtl/tlg_result_if.sv
hw/rtl/tlg_cfg_if.sv
hw/rtl/tlg_decode.sv
hw/rtl/tlg_divide.sv
hw/rtl/tlg_place.sv
hw/rtl/tile_layout_geometry_top.sv
bench/tile_layout_geometry_top_tb.sv
